>>> hdl/rrss_pkg.sv
package rrss_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int ID_W      = 8;
   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int QUANTUM_W = 16;
   localparam int TIME_W    = 21;

   localparam logic [TIME_W-1:0]    TIME_MAX      = 21'h1F_FFFF;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam int   CSR_ADDR_W  = 3;
   localparam int   CSR_DATA_W  = 32;
   localparam logic CSR_QUANTUM = 1'b0;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic [BURST_W-1:0] remaining;
      logic [ARR_W-1:0]   arrival;
      logic [ID_W-1:0]    ident;
   } task_type;

   typedef struct packed {
      logic               all_done;
      logic               task_finished;
      logic [BURST_W-1:0] remaining_after;
      logic [TIME_W-1:0]  slice_end;
      logic [TIME_W-1:0]  slice_start;
      logic [ID_W-1:0]    slice_task;
   } rsp_type;

endpackage

>>> hdl/rrss_ram.sv
module rrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/round_robin_slice_scheduler_core.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: op; tdata: task_id, arrival_time, burst_time
// rsp       out  rsp_tvalid/rsp_tready  tuser: slice_valid; tdata: slice record
// csr       in   csr_psel/csr_penable   quantum at byte address 0
//
// A load writes its table entry straight from idle. A step walks the task table, which
// sits in one RAM with one read port, up to three times, one entry per cycle, and may also
// wait on rsp. Reset clears control state only; the table needs no clearing pass. A new
// item is taken while a result still waits on rsp; a finished step holds until the output
// register is free.
module round_robin_slice_scheduler_core #(
   parameter int MAX_TASKS = rrss_pkg::MAX_TASKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rrss_pkg::REQ_DATA_W-1:0]   req_tdata,   // task_id, arrival_time, burst_time
   input  logic                              req_tuser,   // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rrss_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // slice_task, slice_start,
                                                          // slice_end, remaining_after,
                                                          // task_finished, all_done
   output logic                              rsp_tuser,   // slice_valid
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rrss_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rrss_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rrss_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rrss_pkg::*;

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] FULL    = CW'(MAX_TASKS);
   localparam logic [IW-1:0] LAST_IX = IW'(MAX_TASKS - 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_POP  = 6'b000100,
      ST_SLOT = 6'b001000,
      ST_RUN  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PASS_FIRST  = 3'b001,
      PASS_SECOND = 3'b010,
      PASS_AFTER  = 3'b100
   } pass_type;

   state_type            state_ff, state_in;
   pass_type             pass_ff, pass_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic [IW-1:0]        scan_slot_ff, scan_slot_in;
   logic                 found_ff, found_in;
   logic [ARR_W-1:0]     earliest_ff, earliest_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [CW-1:0]        task_count_ff, task_count_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        rcount_ff, rcount_in;
   logic [MAX_TASKS-1:0] pending_ff, pending_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   rsp_type              res_ff, res_in;
   logic                 res_valid_ff, res_valid_in;
   rsp_type              out_ff, out_in;
   logic                 out_user_ff, out_user_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 task_we;
   logic [IW-1:0]        task_waddr;
   task_type             task_wdata;
   logic [IW-1:0]        task_raddr;
   task_type             task_rdata;
   logic                 fifo_we;
   logic [IW-1:0]        fifo_wdata;
   logic [IW-1:0]        fifo_rdata;

   logic                 req_fire;
   logic                 csr_write;
   logic                 issue_more;
   logic                 scan_done;
   logic                 admit;
   logic                 later;
   logic                 out_free;
   logic [BURST_W-1:0]   run_len;
   logic [TIME_W:0]      end_sum;
   logic [TIME_W-1:0]    end_time;
   logic [BURST_W-1:0]   rem_new;
   logic [IW-1:0]        head_next;
   logic [IW-1:0]        tail_next;

   rrss_ram #(
      .WIDTH ($bits(task_type)),
      .DEPTH (MAX_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (task_we),
      .wr_addr (task_waddr),
      .wr_data (task_wdata),
      .rd_addr (task_raddr),
      .rd_data (task_rdata)
   );

   rrss_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_TASKS)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_QUANTUM) ?
                       CSR_DATA_W'(quantum_ff) : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_ff);
   assign rsp_tuser  = out_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign issue_more = (issue_ff < task_count_ff);
   assign scan_done  = (state_ff == ST_SCAN) && !issue_more && !scan_vld_ff;
   assign admit      = scan_vld_ff && pending_ff[scan_slot_ff] &&
                       (TIME_W'(task_rdata.arrival) <= now_ff);
   assign later      = scan_vld_ff && pending_ff[scan_slot_ff] && !admit;

   assign run_len  = (task_rdata.remaining < quantum_ff) ? task_rdata.remaining : quantum_ff;
   assign end_sum  = {1'b0, now_ff} + (TIME_W + 1)'(run_len);
   assign end_time = (end_sum > (TIME_W + 1)'(TIME_MAX)) ? TIME_MAX : end_sum[TIME_W-1:0];
   assign rem_new  = task_rdata.remaining - run_len;

   assign head_next = (head_ff == LAST_IX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IX) ? '0 : tail_ff + 1'b1;

   assign task_raddr = (state_ff == ST_SLOT) ? fifo_rdata : issue_ff[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      issue_in      = issue_ff;
      scan_vld_in   = 1'b0;
      scan_slot_in  = issue_ff[IW-1:0];
      found_in      = found_ff;
      earliest_in   = earliest_ff;
      now_in        = now_ff;
      task_count_in = task_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rcount_in     = rcount_ff;
      pending_in    = pending_ff;
      slot_in       = slot_ff;
      quantum_in    = quantum_ff;
      res_in        = res_ff;
      res_valid_in  = res_valid_ff;
      out_in        = out_ff;
      out_user_in   = out_user_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      task_we       = 1'b0;
      task_waddr    = task_count_ff[IW-1:0];
      task_wdata    = '{remaining: req_tdata[39:24],
                        arrival:   req_tdata[23:8],
                        ident:     req_tdata[7:0]};
      fifo_we       = 1'b0;
      fifo_wdata    = scan_slot_ff;

      if (csr_write && csr_paddr[2] == CSR_QUANTUM) begin
         quantum_in = csr_pwdata[QUANTUM_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_LOAD) begin
                  if (task_count_ff != FULL) begin
                     task_we       = 1'b1;
                     pending_in[task_count_ff[IW-1:0]] = 1'b1;
                     task_count_in = task_count_ff + 1'b1;
                  end
               end else begin
                  state_in = ST_SCAN;
                  pass_in  = PASS_FIRST;
                  issue_in = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               scan_vld_in = 1'b1;
               issue_in    = issue_ff + 1'b1;
            end
            if (admit) begin
               pending_in[scan_slot_ff] = 1'b0;
               if (rcount_ff != FULL) begin
                  fifo_we   = 1'b1;
                  tail_in   = tail_next;
                  rcount_in = rcount_ff + 1'b1;
               end
            end
            if (later && (!found_ff || task_rdata.arrival < earliest_ff)) begin
               found_in    = 1'b1;
               earliest_in = task_rdata.arrival;
            end
            if (scan_done) begin
               priority if (pass_ff == PASS_AFTER) begin
                  if (!res_ff.task_finished && rcount_ff != FULL) begin
                     fifo_we    = 1'b1;
                     fifo_wdata = slot_ff;
                     tail_in    = tail_next;
                     rcount_in  = rcount_ff + 1'b1;
                  end
                  res_in.all_done = !found_ff && (rcount_ff == '0) && res_ff.task_finished;
                  state_in        = ST_EMIT;
               end else if (rcount_ff != '0) begin
                  state_in = ST_POP;
               end else if (pass_ff == PASS_FIRST && found_ff) begin
                  now_in   = TIME_W'(earliest_ff);
                  pass_in  = PASS_SECOND;
                  issue_in = '0;
                  found_in = 1'b0;
               end else begin
                  res_in          = '0;
                  res_in.all_done = 1'b1;
                  res_valid_in    = 1'b0;
                  state_in        = ST_EMIT;
               end
            end
         end
         ST_POP: begin
            head_in   = head_next;
            rcount_in = rcount_ff - 1'b1;
            state_in  = ST_SLOT;
         end
         ST_SLOT: begin
            slot_in  = fifo_rdata;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            task_we    = 1'b1;
            task_waddr = slot_ff;
            task_wdata = '{remaining: rem_new,
                           arrival:   task_rdata.arrival,
                           ident:     task_rdata.ident};
            res_in.slice_task      = task_rdata.ident;
            res_in.slice_start     = now_ff;
            res_in.slice_end       = end_time;
            res_in.remaining_after = rem_new;
            res_in.task_finished   = (rem_new == '0);
            res_in.all_done        = 1'b0;
            res_valid_in           = 1'b1;
            now_in                 = end_time;
            pass_in                = PASS_AFTER;
            issue_in               = '0;
            found_in               = 1'b0;
            state_in               = ST_SCAN;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_in       = res_ff;
               out_user_in  = res_valid_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pass_ff       <= PASS_FIRST;
         issue_ff      <= '0;
         scan_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         now_ff        <= '0;
         task_count_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rcount_ff     <= '0;
         pending_ff    <= '0;
         quantum_ff    <= QUANTUM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         issue_ff      <= issue_in;
         scan_vld_ff   <= scan_vld_in;
         found_ff      <= found_in;
         now_ff        <= now_in;
         task_count_ff <= task_count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rcount_ff     <= rcount_in;
         pending_ff    <= pending_in;
         quantum_ff    <= quantum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_slot_ff <= scan_slot_in;
      earliest_ff  <= earliest_in;
      slot_ff      <= slot_in;
      res_ff       <= res_in;
      res_valid_ff <= res_valid_in;
      out_ff       <= out_in;
      out_user_ff  <= out_user_in;
   end

   a_ready_le_tasks: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= task_count_ff)
      else $error("ready queue holds more items than loaded tasks");

   a_queue_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (rcount_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ready queue with head and tail apart");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      scan_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read in flight outside scan");

   a_load_steady_time: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_LOAD) |=> $stable(now_ff))
      else $error("load changed the current time");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rrss_pkg::*;

   localparam int TASK_SLOTS  = MAX_TASKS_DEF;
   localparam int DRAIN_WAIT  = 64;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_ADDR_W-1:0] QUANTUM_ADDR = CSR_ADDR_W'(4 * CSR_QUANTUM);

   typedef struct packed {
      logic    valid;
      rsp_type rec;
   } slice_rec_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // scheduler shadow state
   logic [ID_W-1:0]      sched_ident   [TASK_SLOTS];
   logic [ARR_W-1:0]     sched_arrival [TASK_SLOTS];
   logic [BURST_W-1:0]   sched_remain  [TASK_SLOTS];
   logic                 sched_pending [TASK_SLOTS];
   int                   task_total    = 0;
   int                   ready_slots[$];
   logic [TIME_W-1:0]    now_tm        = '0;
   logic [QUANTUM_W-1:0] quantum_q     = QUANTUM_RESET;
   logic                 last_all_done = 1'b0;

   slice_rec_type slice_expect[$];

   logic idle_on     = 1'b1;
   int   hold_ask    = 0;
   int   hold_seen   = 0;
   int   hold_left   = 0;
   int   stall_left  = 0;
   int   mismatches  = 0;
   int   cycle_count = 0;

   round_robin_slice_scheduler_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("round_robin_slice_scheduler_core test failed");
         $finish;
      end
   end

   function automatic void admit_ready();
      for (int i = 0; i < task_total; i++) begin
         if (sched_pending[i] && TIME_W'(sched_arrival[i]) <= now_tm) begin
            sched_pending[i] = 1'b0;
            ready_slots.push_back(i);
         end
      end
   endfunction

   function automatic void find_first_arrival(output logic found, output logic [ARR_W-1:0] best);
      found = 1'b0;
      best  = '0;
      for (int i = 0; i < task_total; i++) begin
         if (sched_pending[i] && (!found || sched_arrival[i] < best)) begin
            best  = sched_arrival[i];
            found = 1'b1;
         end
      end
   endfunction

   function automatic void store_task(task_type t);
      if (task_total < TASK_SLOTS) begin
         sched_ident[task_total]   = t.ident;
         sched_arrival[task_total] = t.arrival;
         sched_remain[task_total]  = t.remaining;
         sched_pending[task_total] = 1'b1;
         task_total++;
      end
   endfunction

   function automatic slice_rec_type predict_slice();
      slice_rec_type      r;
      int                 slot;
      logic [BURST_W-1:0] run_len;
      logic [TIME_W:0]    end_wide;
      logic               found;
      logic [ARR_W-1:0]   first_arr;
      r = '0;
      admit_ready();
      if (ready_slots.size() == 0) begin
         find_first_arrival(found, first_arr);
         if (found && TIME_W'(first_arr) > now_tm) now_tm = TIME_W'(first_arr);
         admit_ready();
      end
      if (ready_slots.size() == 0) begin
         r.rec.all_done = 1'b1;
         last_all_done  = 1'b1;
         return r;
      end
      slot     = ready_slots.pop_front();
      run_len  = (sched_remain[slot] < quantum_q) ? sched_remain[slot] : quantum_q;
      r.rec.slice_start = now_tm;
      end_wide = {1'b0, now_tm} + (TIME_W + 1)'(run_len);
      now_tm   = (end_wide > (TIME_W + 1)'(TIME_MAX)) ? TIME_MAX : end_wide[TIME_W-1:0];
      sched_remain[slot] = sched_remain[slot] - run_len;
      admit_ready();
      if (sched_remain[slot] != '0) ready_slots.push_back(slot);
      find_first_arrival(found, first_arr);
      r.valid                 = 1'b1;
      r.rec.slice_task        = sched_ident[slot];
      r.rec.slice_end         = now_tm;
      r.rec.remaining_after   = sched_remain[slot];
      r.rec.task_finished     = (sched_remain[slot] == '0);
      r.rec.all_done          = (ready_slots.size() == 0) && !found;
      last_all_done           = r.rec.all_done;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      slice_rec_type want;
      rsp_type       got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_type)-1:0];
         if (slice_expect.size() == 0) begin
            $display("%0t unexpected slice record expected none actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = slice_expect.pop_front();
            check_field("slice_valid", 32'(want.valid), 32'(rsp_tuser));
            check_field("slice_task", 32'(want.rec.slice_task), 32'(got.slice_task));
            check_field("slice_start", 32'(want.rec.slice_start), 32'(got.slice_start));
            check_field("slice_end", 32'(want.rec.slice_end), 32'(got.slice_end));
            check_field("remaining_after", 32'(want.rec.remaining_after),
                        32'(got.remaining_after));
            check_field("task_finished", 32'(want.rec.task_finished),
                        32'(got.task_finished));
            check_field("all_done", 32'(want.rec.all_done), 32'(got.all_done));
            check_field("padding", 0, 32'(rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)]));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_seen != hold_ask) begin
         hold_seen  <= hold_ask;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic op, task_type t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) store_task(t);
      else slice_expect.push_back(predict_slice());
   endtask

   task automatic load_task(logic [ID_W-1:0] id, logic [ARR_W-1:0] arr, logic [BURST_W-1:0] burst);
      task_type t;
      t.ident     = id;
      t.arrival   = arr;
      t.remaining = burst;
      send_item(OP_LOAD, t);
   endtask

   task automatic step_once();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      send_item(OP_STEP, noise[REQ_DATA_W-1:0]);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (slice_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_quantum(logic [QUANTUM_W-1:0] q);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= QUANTUM_ADDR;
      csr_pwdata  <= {16'd0, q};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      quantum_q   = q;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("quantum", {16'd0, q}, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_empty_table();
      step_once();
   endtask

   task automatic test_rotation_order();
      load_task(8'h00, 16'd0, 16'd0);
      load_task(8'h5A, 16'd3, 16'd10);
      load_task(8'hA5, 16'd9, 16'd2);
      repeat (6) step_once();
   endtask

   task automatic test_zero_quantum();
      write_quantum(16'd0);
      load_task(8'h3C, 16'd0, 16'd5);
      repeat (2) step_once();
      write_quantum(16'd1);
      repeat (5) step_once();
   endtask

   task automatic test_random_mix();
      logic [QUANTUM_W-1:0] q;
      logic [ARR_W-1:0]     arr;
      logic [BURST_W-1:0]   burst;
      logic [TIME_W:0]      wide;
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 0) q = 16'd1;
         else if (ph == 3) q = QUANTUM_W'($urandom_range(7, 40));
         else q = QUANTUM_W'($urandom_range(2, 6));
         write_quantum(q);
         idle_on <= (ph != 3);
         if (ph == 2) hold_ask <= hold_ask + 1;
         for (int k = 0; k < 80; k++) begin
            if (task_total < TASK_SLOTS - 1 && $urandom_range(0, 19) == 0) begin
               if ($urandom_range(0, 9) == 0) begin
                  arr = (now_tm > TIME_W'(16'hFFFF)) ? ARR_W'($urandom_range(0, 16'hFFFF))
                                                     : ARR_W'($urandom_range(0, now_tm));
               end else begin
                  wide = (TIME_W + 1)'(now_tm) + (TIME_W + 1)'($urandom_range(0, 300));
                  arr  = (wide > (TIME_W + 1)'(16'hFFFF)) ? 16'hFFFF : wide[ARR_W-1:0];
               end
               burst = ($urandom_range(0, 7) == 0) ? 16'd0
                                                   : BURST_W'($urandom_range(1, 160));
               load_task(ID_W'($urandom_range(0, 255)), arr, burst);
            end else begin
               step_once();
            end
         end
      end
   endtask

   task automatic test_full_table_drain();
      int n;
      n = 0;
      write_quantum(16'hFFFF);
      idle_on <= 1'b0;
      load_task(8'hFF, 16'hFFFF, 16'hFFFF);
      load_task(ID_W'($urandom_range(0, 255)), ARR_W'($urandom_range(0, 16'hFFFF)),
                BURST_W'($urandom_range(0, 16'hFFFF)));
      load_task(ID_W'($urandom_range(0, 255)), 16'd0, 16'd1);
      last_all_done = 1'b0;
      while (!last_all_done && n < 40) begin
         step_once();
         n++;
      end
      step_once();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_rotation_order();
      test_zero_quantum();
      test_random_mix();
      test_full_table_drain();
      settle();
      if (mismatches == 0) begin
         $display("round_robin_slice_scheduler_core test passed");
      end else begin
         $display("round_robin_slice_scheduler_core test failed");
      end
      $finish;
   end

endmodule

>>> round_robin_slice_scheduler_core.f
hdl/rrss_pkg.sv
hdl/rrss_ram.sv
hdl/round_robin_slice_scheduler_core.sv
test/tb_top.sv
